// ----- hdl/lfs_pkg.sv -----
// Package: steering modes, register indexes and widths for the line-follow steering block.
package lfs_pkg;

   localparam int SENSOR_COUNT = 5;
   localparam int LEVEL_W      = 8;
   localparam int MODE_W       = 3;
   localparam int DARK_W       = 9;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   typedef logic [SENSOR_COUNT-1:0] sensors_type;
   typedef logic [LEVEL_W-1:0]      level_type;
   typedef logic [MODE_W-1:0]       mode_type;
   typedef logic [DARK_W-1:0]       dark_type;

   localparam mode_type M_STRAIGHT   = 3'd0;
   localparam mode_type M_SOFT_LEFT  = 3'd1;
   localparam mode_type M_SOFT_RIGHT = 3'd2;
   localparam mode_type M_HARD_LEFT  = 3'd3;
   localparam mode_type M_HARD_RIGHT = 3'd4;
   localparam mode_type M_FINISHED   = 3'd5;
   localparam mode_type M_NONE       = 3'd7;

   localparam dark_type DARK_MAX = 9'd511;

   localparam logic [2:0] REG_STRAIGHT    = 3'd0;
   localparam logic [2:0] REG_HARD_STRONG = 3'd1;
   localparam logic [2:0] REG_HARD_WEAK   = 3'd2;
   localparam logic [2:0] REG_SOFT_STRONG = 3'd3;
   localparam logic [2:0] REG_SOFT_WEAK   = 3'd4;
   localparam logic [2:0] REG_END_MODE    = 3'd5;
   localparam logic [2:0] REG_DARK_LIMIT  = 3'd6;

   // sensor bit positions, bit0 leftmost
   localparam int S_OUTER_LEFT  = 0;
   localparam int S_INNER_LEFT  = 1;
   localparam int S_CENTER      = 2;
   localparam int S_INNER_RIGHT = 3;
   localparam int S_OUTER_RIGHT = 4;

endpackage

// ----- hdl/lfs_req_if.sv -----
// Interface: request channel carrying restart and a sensor sample.
interface lfs_req_if;
   logic                       valid;
   logic                       ready;
   logic                       restart;
   logic [lfs_pkg::SENSOR_COUNT-1:0] sensors;

   modport source (output valid, output restart, output sensors, input ready);
   modport sink   (input valid, input restart, input sensors, output ready);
endinterface

// ----- hdl/lfs_rsp_if.sv -----
// Interface: response channel carrying wheel drive levels and steering mode.
interface lfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_drive;
   logic [7:0] right_drive;
   logic       drive_update;
   logic [2:0] mode;
   logic       finished;

   modport source (output valid, output left_drive, output right_drive,
                   output drive_update, output mode, output finished, input ready);
   modport sink   (input valid, input left_drive, input right_drive,
                   input drive_update, input mode, input finished, output ready);
endinterface

// ----- hdl/line_follow_steering_fsm_top.sv -----
// Top level: line-follow steering controller with APB-style register port.
// Datapath: the input register loads at acceptance; the response register and the
//   steering state load together once the response slot is free or being taken.
// Throughput: 1 request per cycle while the response side is ready; the response register
//   and the input register decouple the two channels so a request is taken while a response waits.
// Reset: synchronous, active high; mode finished, dark count and levels zero,
//   previous mode set to "none", configuration registers zero, both channels empty.
module line_follow_steering_fsm_top (
   input  logic                              clock,
   input  logic                              reset,
   lfs_req_if.sink                           req_ch,
   lfs_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lfs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lfs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import lfs_pkg::*;

   // configuration registers
   level_type straight_ff, hard_strong_ff, hard_weak_ff, soft_strong_ff, soft_weak_ff;
   level_type dark_limit_ff;
   logic      end_mode_ff;

   // steering state
   mode_type  steer_mode_ff, steer_mode_in;
   mode_type  prev_mode_ff, prev_mode_in;
   dark_type  dark_count_ff, dark_count_in;
   level_type left_level_ff, left_level_in;
   level_type right_level_ff, right_level_in;
   logic      update_in;

   // input register
   logic        s1_valid_ff;
   logic        s1_restart_ff;
   sensors_type s1_sensors_ff;

   // response register
   logic      rsp_valid_ff;
   level_type rsp_left_ff, rsp_right_ff;
   logic      rsp_update_ff;
   mode_type  rsp_mode_ff;

   logic       advance;
   logic       req_take;
   logic       csr_write;
   logic [2:0] csr_index;
   logic       end_run;
   dark_type   dark_inc;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         REG_STRAIGHT:    prdata = {24'd0, straight_ff};
         REG_HARD_STRONG: prdata = {24'd0, hard_strong_ff};
         REG_HARD_WEAK:   prdata = {24'd0, hard_weak_ff};
         REG_SOFT_STRONG: prdata = {24'd0, soft_strong_ff};
         REG_SOFT_WEAK:   prdata = {24'd0, soft_weak_ff};
         REG_END_MODE:    prdata = {31'd0, end_mode_ff};
         REG_DARK_LIMIT:  prdata = {24'd0, dark_limit_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         straight_ff    <= '0;
         hard_strong_ff <= '0;
         hard_weak_ff   <= '0;
         soft_strong_ff <= '0;
         soft_weak_ff   <= '0;
         end_mode_ff    <= 1'b0;
         dark_limit_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_STRAIGHT:    straight_ff    <= pwdata[LEVEL_W-1:0];
            REG_HARD_STRONG: hard_strong_ff <= pwdata[LEVEL_W-1:0];
            REG_HARD_WEAK:   hard_weak_ff   <= pwdata[LEVEL_W-1:0];
            REG_SOFT_STRONG: soft_strong_ff <= pwdata[LEVEL_W-1:0];
            REG_SOFT_WEAK:   soft_weak_ff   <= pwdata[LEVEL_W-1:0];
            REG_END_MODE:    end_mode_ff    <= pwdata[0];
            REG_DARK_LIMIT:  dark_limit_ff  <= pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the input register moves on whenever the response slot frees up
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_restart_ff <= req_ch.restart;
         s1_sensors_ff <= req_ch.sensors;
      end
   end

   // next steering state for the request held in the input register
   assign dark_inc = (dark_count_ff < DARK_MAX) ? dark_count_ff + 9'd1 : dark_count_ff;

   always_comb begin
      steer_mode_in  = steer_mode_ff;
      prev_mode_in   = prev_mode_ff;
      dark_count_in  = dark_count_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      update_in      = 1'b0;
      end_run        = 1'b0;
      if (s1_restart_ff) begin
         steer_mode_in  = M_STRAIGHT;
         prev_mode_in   = M_NONE;
         dark_count_in  = '0;
         left_level_in  = straight_ff;
         right_level_in = straight_ff;
         update_in      = 1'b1;
      end else if (steer_mode_ff != M_FINISHED) begin
         if (!end_mode_ff) begin
            end_run = s1_sensors_ff[S_OUTER_LEFT] || s1_sensors_ff[S_OUTER_RIGHT];
         end else if (s1_sensors_ff == '0) begin
            dark_count_in = dark_inc;
            end_run       = dark_inc > {1'b0, dark_limit_ff};
         end else begin
            dark_count_in = '0;
         end

         if (end_run) begin
            steer_mode_in = M_FINISHED;
         end else if (s1_sensors_ff[S_CENTER]) begin
            if (steer_mode_ff != M_STRAIGHT) begin
               prev_mode_in   = steer_mode_ff;
               steer_mode_in  = M_STRAIGHT;
               left_level_in  = straight_ff;
               right_level_in = straight_ff;
               update_in      = 1'b1;
            end
         end else if (s1_sensors_ff[S_INNER_LEFT]) begin
            if (steer_mode_ff != M_SOFT_LEFT) begin
               steer_mode_in  = M_SOFT_LEFT;
               left_level_in  = soft_weak_ff;
               right_level_in = soft_strong_ff;
               update_in      = 1'b1;
            end
         end else if (s1_sensors_ff[S_INNER_RIGHT]) begin
            if (steer_mode_ff != M_SOFT_RIGHT) begin
               steer_mode_in  = M_SOFT_RIGHT;
               left_level_in  = soft_strong_ff;
               right_level_in = soft_weak_ff;
               update_in      = 1'b1;
            end
         end else if (steer_mode_ff == M_STRAIGHT) begin
            // line lost from straight: swing opposite to the previous mode if it was a hard turn
            if (prev_mode_ff == M_HARD_LEFT) begin
               steer_mode_in  = M_HARD_RIGHT;
               left_level_in  = hard_strong_ff;
               right_level_in = hard_weak_ff;
               update_in      = 1'b1;
            end else if (prev_mode_ff == M_HARD_RIGHT) begin
               steer_mode_in  = M_HARD_LEFT;
               left_level_in  = hard_weak_ff;
               right_level_in = hard_strong_ff;
               update_in      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_mode_ff  <= M_FINISHED;
         prev_mode_ff   <= M_NONE;
         dark_count_ff  <= '0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
      end else if (advance) begin
         steer_mode_ff  <= steer_mode_in;
         prev_mode_ff   <= prev_mode_in;
         dark_count_ff  <= dark_count_in;
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_ff   <= left_level_in;
         rsp_right_ff  <= right_level_in;
         rsp_update_ff <= update_in;
         rsp_mode_ff   <= steer_mode_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.left_drive   = rsp_left_ff;
   assign rsp_ch.right_drive  = rsp_right_ff;
   assign rsp_ch.drive_update = rsp_update_ff;
   assign rsp_ch.mode         = rsp_mode_ff;
   assign rsp_ch.finished     = (rsp_mode_ff == M_FINISHED);

   a_restart_straight: assert property (@(posedge clock) disable iff (reset)
      advance && s1_restart_ff |=> steer_mode_ff == M_STRAIGHT && dark_count_ff == '0)
      else $error("restart did not start a straight run");

   a_update_not_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_update_ff |-> rsp_mode_ff != M_FINISHED)
      else $error("drive update reported on a finished run");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_mode_ff == steer_mode_ff && rsp_left_ff == left_level_ff
                  && rsp_right_ff == right_level_ff)
      else $error("response does not match steering state");

   a_finished_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_restart_ff && steer_mode_ff == M_FINISHED
      |=> steer_mode_ff == M_FINISHED && $stable(left_level_ff) && !rsp_update_ff)
      else $error("finished run changed without restart");

endmodule

// ----- test/lfs_steer_checker.sv -----
// Checker: predicts the steering response of each accepted request and compares it.
`timescale 1ns / 100ps
module lfs_steer_checker (
   input  logic                           clock,
   input  logic                           reset,
   lfs_req_if                             req_ch,
   lfs_rsp_if                             rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lfs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lfs_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   input  logic                           drained,
   output int unsigned                    fail_count,
   output int unsigned                    outstanding
);
   import lfs_pkg::*;

   typedef struct packed {
      level_type left_drive;
      level_type right_drive;
      logic      drive_update;
      mode_type  mode;
      logic      finished;
   } drive_report_type;

   level_type lvl_straight;
   level_type lvl_hard_strong;
   level_type lvl_hard_weak;
   level_type lvl_soft_strong;
   level_type lvl_soft_weak;
   level_type dark_limit;
   logic      lost_line_mode;

   mode_type  cur_mode;
   mode_type  prev_mode;
   dark_type  dark_run;
   level_type left_lvl;
   level_type right_lvl;

   drive_report_type expected_drives [$];
   logic             leftover_told = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic drive_report_type advance_steering(input logic restart,
                                                         input sensors_type s);
      drive_report_type res;
      logic             run_ends;
      logic             issued;
      mode_type         next_mode;
      level_type        next_left;
      level_type        next_right;
      run_ends   = 1'b0;
      issued     = 1'b0;
      next_mode  = cur_mode;
      next_left  = left_lvl;
      next_right = right_lvl;
      if (restart) begin
         prev_mode  = M_NONE;
         dark_run   = '0;
         next_mode  = M_STRAIGHT;
         next_left  = lvl_straight;
         next_right = lvl_straight;
         issued     = 1'b1;
      end else if (cur_mode != M_FINISHED) begin
         if (!lost_line_mode) begin
            run_ends = s[S_OUTER_LEFT] | s[S_OUTER_RIGHT];
         end else if (s == '0) begin
            // saturate the dark run, end once it passes the tolerated count
            if (dark_run != DARK_MAX) dark_run = dark_run + 1'b1;
            run_ends = dark_run > {1'b0, dark_limit};
         end else begin
            dark_run = '0;
         end

         if (run_ends) begin
            next_mode = M_FINISHED;
         end else if (s[S_CENTER]) begin
            if (cur_mode != M_STRAIGHT) begin
               prev_mode  = cur_mode;
               next_mode  = M_STRAIGHT;
               next_left  = lvl_straight;
               next_right = lvl_straight;
               issued     = 1'b1;
            end
         end else if (s[S_INNER_LEFT]) begin
            if (cur_mode != M_SOFT_LEFT) begin
               next_mode  = M_SOFT_LEFT;
               next_left  = lvl_soft_weak;
               next_right = lvl_soft_strong;
               issued     = 1'b1;
            end
         end else if (s[S_INNER_RIGHT]) begin
            if (cur_mode != M_SOFT_RIGHT) begin
               next_mode  = M_SOFT_RIGHT;
               next_left  = lvl_soft_strong;
               next_right = lvl_soft_weak;
               issued     = 1'b1;
            end
         end else if (cur_mode == M_STRAIGHT && prev_mode == M_HARD_LEFT) begin
            next_mode  = M_HARD_RIGHT;
            next_left  = lvl_hard_strong;
            next_right = lvl_hard_weak;
            issued     = 1'b1;
         end else if (cur_mode == M_STRAIGHT && prev_mode == M_HARD_RIGHT) begin
            next_mode  = M_HARD_LEFT;
            next_left  = lvl_hard_weak;
            next_right = lvl_hard_strong;
            issued     = 1'b1;
         end
      end
      cur_mode  = next_mode;
      left_lvl  = next_left;
      right_lvl = next_right;

      res.left_drive   = left_lvl;
      res.right_drive  = right_lvl;
      res.drive_update = issued;
      res.mode         = cur_mode;
      res.finished     = (cur_mode == M_FINISHED);
      return res;
   endfunction

   always @(posedge clock) begin
      drive_report_type got;
      drive_report_type want;
      if (reset) begin
         fail_count      = 0;
         lvl_straight    = '0;
         lvl_hard_strong = '0;
         lvl_hard_weak   = '0;
         lvl_soft_strong = '0;
         lvl_soft_weak   = '0;
         dark_limit      = '0;
         lost_line_mode  = 1'b0;
         cur_mode        = M_FINISHED;
         prev_mode       = M_NONE;
         dark_run        = '0;
         left_lvl        = '0;
         right_lvl       = '0;
         expected_drives.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_STRAIGHT:    lvl_straight    = pwdata[LEVEL_W-1:0];
               REG_HARD_STRONG: lvl_hard_strong = pwdata[LEVEL_W-1:0];
               REG_HARD_WEAK:   lvl_hard_weak   = pwdata[LEVEL_W-1:0];
               REG_SOFT_STRONG: lvl_soft_strong = pwdata[LEVEL_W-1:0];
               REG_SOFT_WEAK:   lvl_soft_weak   = pwdata[LEVEL_W-1:0];
               REG_END_MODE:    lost_line_mode  = pwdata[0];
               REG_DARK_LIMIT:  dark_limit      = pwdata[LEVEL_W-1:0];
               default: ;
            endcase
         end

         // compare before predicting: a response never belongs to this edge's request
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.left_drive, rsp_ch.right_drive, rsp_ch.drive_update,
                    rsp_ch.mode, rsp_ch.finished};
            if (expected_drives.size() == 0) begin
               report_mismatch($sformatf("response with no request pending (mode %0d)",
                                         got.mode));
            end else begin
               want = expected_drives.pop_front();
               compare_field("left_drive", got.left_drive, want.left_drive);
               compare_field("right_drive", got.right_drive, want.right_drive);
               compare_field("drive_update", got.drive_update, want.drive_update);
               compare_field("mode", got.mode, want.mode);
               compare_field("finished", got.finished, want.finished);
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            expected_drives.push_back(advance_steering(req_ch.restart, req_ch.sensors));
         end

         if (drained && !leftover_told && expected_drives.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived", expected_drives.size()));
            leftover_told = 1'b1;
         end
      end
      outstanding = expected_drives.size();
   end

endmodule

// ----- test/tb_line_follow_steering_fsm_top.sv -----
// Testbench top: drives sensor requests and register writes into the steering block.
`timescale 1ns / 100ps
module tb_line_follow_steering_fsm_top;
   import lfs_pkg::*;

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = RANDOM_ITEMS / PHASES;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  drained = 1'b0;
   logic                  idle_on = 1'b1;
   int unsigned           chk_fail_count;
   int unsigned           chk_outstanding;
   int unsigned           sent_items = 0;
   int unsigned           stall_left = 0;
   logic                  cfg_lost_line = 1'b0;
   level_type             cfg_dark_limit = '0;

   lfs_req_if req_if ();
   lfs_rsp_if rsp_if ();

   line_follow_steering_fsm_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   lfs_steer_checker steer_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .drained     (drained),
      .fail_count  (chk_fail_count),
      .outstanding (chk_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // stall the response side in short bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // entered and left at a falling edge; valid stays high for a following request
   task automatic send_request(input logic restart, input sensors_type s);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.restart = restart;
      req_if.sensors = s;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      sent_items++;
      idle_on = (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS - 250);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // upper data bits are noise; only the low bits of each register count
   task automatic configure(input level_type straight, input level_type hard_strong,
                            input level_type hard_weak, input level_type soft_strong,
                            input level_type soft_weak, input logic lost_line,
                            input level_type limit);
      req_if.valid = 1'b0;
      while (chk_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(REG_STRAIGHT, {24'($urandom), straight});
      write_reg(REG_HARD_STRONG, {24'($urandom), hard_strong});
      write_reg(REG_HARD_WEAK, {24'($urandom), hard_weak});
      write_reg(REG_SOFT_STRONG, {24'($urandom), soft_strong});
      write_reg(REG_SOFT_WEAK, {24'($urandom), soft_weak});
      write_reg(REG_END_MODE, {31'($urandom), lost_line});
      write_reg(REG_DARK_LIMIT, {24'($urandom), limit});
      cfg_lost_line  = lost_line;
      cfg_dark_limit = limit;
   endtask

   function automatic sensors_type pick_sensors();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 14) begin
         return sensors_type'($urandom_range(0, 31)) |
                ($urandom_range(0, 1) ? 5'b10000 : 5'b00001);
      end
      if (r < 88) begin
         case ($urandom_range(0, 6))
            0:       return 5'b00100;
            1:       return 5'b00110;
            2:       return 5'b01100;
            3:       return 5'b00010;
            4:       return 5'b01000;
            5:       return 5'b01110;
            default: return 5'b01010;
         endcase
      end
      return sensors_type'($urandom_range(0, 31));
   endfunction

   // track the end of the run alongside, so runs stop where the block stops
   task automatic send_sample(input sensors_type s, inout int dark_streak, inout logic ended);
      send_request(1'b0, s);
      if (!cfg_lost_line) begin
         ended = s[S_OUTER_LEFT] | s[S_OUTER_RIGHT];
      end else if (s == '0) begin
         dark_streak++;
         ended = dark_streak > int'(cfg_dark_limit);
      end else begin
         dark_streak = 0;
      end
   endtask

   task automatic run_sequence();
      int   samples;
      int   dark_streak;
      int   streak_len;
      logic ended;
      logic streak_used;
      send_request(1'b1, sensors_type'($urandom_range(0, 31)));
      samples     = $urandom_range(2, 40);
      dark_streak = 0;
      ended       = 1'b0;
      streak_used = 1'b0;
      while (samples > 0 && !ended) begin
         if (cfg_lost_line && !streak_used && $urandom_range(0, 9) == 0) begin
            // go dark up to the tolerated count, or one past it
            streak_used = 1'b1;
            streak_len  = int'(cfg_dark_limit) + $urandom_range(0, 1);
            for (int i = 0; i < streak_len && !ended; i++) send_sample('0, dark_streak, ended);
         end else begin
            send_sample(pick_sensors(), dark_streak, ended);
         end
         samples--;
      end
      if (ended) begin
         repeat ($urandom_range(0, 2)) send_request(1'b0, sensors_type'($urandom_range(0, 31)));
      end
   endtask

   initial begin
      level_type limit;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      req_if.sensors = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // finished out of reset: samples change nothing until a restart
      send_request(1'b0, 5'b00100);
      send_request(1'b0, 5'b11111);

      configure(8'h80, 8'hFF, 8'h00, 8'hC0, 8'h40, 1'b0, 8'h00);
      send_request(1'b1, 5'b11111);
      send_request(1'b0, 5'b00100);
      send_request(1'b0, 5'b00010);
      send_request(1'b0, 5'b00010);
      send_request(1'b0, 5'b01000);
      send_request(1'b0, 5'b01010);
      send_request(1'b0, 5'b01110);
      send_request(1'b0, 5'b00000);
      send_request(1'b0, 5'b10001);
      send_request(1'b0, 5'b00100);
      send_request(1'b1, 5'b00000);
      send_request(1'b0, 5'b00001);
      send_request(1'b1, 5'b00000);
      send_request(1'b0, 5'b10000);

      // lost-line end with no dark sample tolerated
      configure(8'hFF, 8'h01, 8'hFE, 8'h00, 8'hFF, 1'b1, 8'h00);
      send_request(1'b1, 5'b00000);
      send_request(1'b0, 5'b00000);
      send_request(1'b1, 5'b00000);
      send_request(1'b0, 5'b10001);
      send_request(1'b0, 5'b00010);
      send_request(1'b0, 5'b11111);
      send_request(1'b0, 5'b00000);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
            1: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
            default: begin
               case ($urandom_range(0, 3))
                  0:       limit = 8'd0;
                  1:       limit = 8'd1;
                  2:       limit = level_type'($urandom_range(2, 12));
                  default: limit = 8'hFF;
               endcase
               configure(level_type'($urandom), level_type'($urandom), level_type'($urandom),
                         level_type'($urandom), level_type'($urandom),
                         logic'($urandom_range(0, 1)), limit);
            end
         endcase
         while (sent_items < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS) run_sequence();
      end

      req_if.valid = 1'b0;
      while (chk_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      drained = 1'b1;
      repeat (2) @(negedge clock);
      if (chk_fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
